// ----- rtl/core/kdsl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsl_pkg: shared types and constants of the key debouncer
// Key count, field widths, register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
package kdsl_pkg;

  localparam int NUM_KEYS  = 3;
  localparam int TIME_W    = 32;
  localparam int MS_W      = 16;
  localparam int EVT_W     = 3;
  localparam int IN_DATA_W  = 40;  // 32 + 3 bits, padded to whole bytes
  localparam int OUT_DATA_W = 8;   // 3 + 3 bits, padded to whole bytes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [NUM_KEYS-1:0] key_mask_t;
  typedef logic [TIME_W-1:0]   ms_time_t;
  typedef logic [MS_W-1:0]     ms_cfg_t;
  typedef logic [EVT_W-1:0]    evt_code_t;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_HIGH = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_ENABLE = 2'd3;

  // Reset values
  localparam ms_cfg_t   RST_DEBOUNCE    = 16'd20;
  localparam ms_cfg_t   RST_LONG_PRESS  = 16'd800;
  localparam key_mask_t RST_ACTIVE_HIGH = 3'b100;
  localparam key_mask_t RST_LONG_ENABLE = 3'b110;

  localparam evt_code_t EVT_NONE    = 3'd0;
  localparam evt_code_t EVT_INVALID = 3'd7;

  // Short event of key k is 1+2k, long event is 2+2k
  function automatic evt_code_t short_code(input int k);
    short_code = EVT_W'(1 + 2 * k);
  endfunction

  function automatic evt_code_t long_code(input int k);
    long_code = EVT_W'(2 + 2 * k);
  endfunction

endpackage

// ----- rtl/core/key_debounce_short_long_press.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_short_long_press: three-key debouncer with press events
// The result beat is registered: it shows in the cycle after its poll beat is accepted.
// Throughput: one poll per cycle; the per-key update is a single pass of
// subtract/compare logic feeding the result register.
// The input stalls only while a result beat waits and out_tready is low.
// Reset (synchronous, rst_n low): all keys released, registers to defaults.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press (
  input  logic                                clk,
  input  logic                                rst_n,
  // poll beat
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kdsl_pkg::IN_DATA_W-1:0]      in_tdata,   // [31:0] now_ms, [34:32] pin_levels
  // result beat
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kdsl_pkg::OUT_DATA_W-1:0]     out_tdata,  // [2:0] event_code, [5:3] pressed_mask
  // configuration writes
  input  logic                                cfg_we,
  input  logic [kdsl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [kdsl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int K = kdsl_pkg::NUM_KEYS;

  // configuration
  kdsl_pkg::ms_cfg_t   debounce_r;
  kdsl_pkg::ms_cfg_t   long_press_r;
  kdsl_pkg::key_mask_t active_high_r;
  kdsl_pkg::key_mask_t long_en_r;

  // per-key state
  kdsl_pkg::key_mask_t raw_r, raw_nxt;
  kdsl_pkg::key_mask_t stable_r, stable_nxt;
  kdsl_pkg::key_mask_t long_given_r, long_given_nxt;
  kdsl_pkg::ms_time_t  raw_time_r   [K];
  kdsl_pkg::ms_time_t  raw_time_nxt [K];
  kdsl_pkg::ms_time_t  press_time_r [K];
  kdsl_pkg::ms_time_t  press_time_nxt [K];

  // result register
  logic                 out_valid_r;
  kdsl_pkg::evt_code_t  evt_r, evt_nxt;
  kdsl_pkg::key_mask_t  mask_r, mask_nxt;

  kdsl_pkg::ms_time_t   now_ms;
  kdsl_pkg::key_mask_t  pin_levels;
  logic                 in_fire;

  assign now_ms     = in_tdata[kdsl_pkg::TIME_W-1:0];
  assign pin_levels = in_tdata[kdsl_pkg::TIME_W +: K];
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, mask_r, evt_r};

  // Per-key update; the event slot passes from key 0 upward
  always_comb begin
    kdsl_pkg::ms_time_t elapsed_raw;
    kdsl_pkg::ms_time_t elapsed_press;
    kdsl_pkg::evt_code_t evt;
    logic pressed;
    elapsed_raw   = '0;
    elapsed_press = '0;
    pressed       = 1'b0;
    evt           = kdsl_pkg::EVT_NONE;
    raw_nxt        = raw_r;
    stable_nxt     = stable_r;
    long_given_nxt = long_given_r;
    mask_nxt       = '0;
    for (int k = 0; k < K; k++) begin
      raw_time_nxt[k]   = raw_time_r[k];
      press_time_nxt[k] = press_time_r[k];
      // latch a raw level change
      if (pin_levels[k] != raw_r[k]) begin
        raw_nxt[k]      = pin_levels[k];
        raw_time_nxt[k] = now_ms;
      end
      // promote a raw level that held long enough
      elapsed_raw = now_ms - raw_time_nxt[k];
      if (raw_nxt[k] != stable_r[k] &&
          elapsed_raw >= {{(kdsl_pkg::TIME_W-kdsl_pkg::MS_W){1'b0}}, debounce_r}) begin
        stable_nxt[k] = raw_nxt[k];
        if (raw_nxt[k] == active_high_r[k]) begin
          press_time_nxt[k] = now_ms;
        end else if (!long_given_r[k] && evt == kdsl_pkg::EVT_NONE) begin
          evt = kdsl_pkg::short_code(k);
        end
        long_given_nxt[k] = 1'b0;
      end
      // fire a long event once per press
      pressed       = (stable_nxt[k] == active_high_r[k]);
      elapsed_press = now_ms - press_time_nxt[k];
      if (pressed && long_en_r[k] && !long_given_nxt[k] &&
          elapsed_press >= {{(kdsl_pkg::TIME_W-kdsl_pkg::MS_W){1'b0}}, long_press_r} &&
          evt == kdsl_pkg::EVT_NONE) begin
        long_given_nxt[k] = 1'b1;
        evt = kdsl_pkg::long_code(k);
      end
      mask_nxt[k] = pressed;
    end
    evt_nxt = evt;
  end

  // Control, configuration and key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      debounce_r    <= kdsl_pkg::RST_DEBOUNCE;
      long_press_r  <= kdsl_pkg::RST_LONG_PRESS;
      active_high_r <= kdsl_pkg::RST_ACTIVE_HIGH;
      long_en_r     <= kdsl_pkg::RST_LONG_ENABLE;
      raw_r         <= ~kdsl_pkg::RST_ACTIVE_HIGH;
      stable_r      <= ~kdsl_pkg::RST_ACTIVE_HIGH;
      long_given_r  <= '0;
      for (int k = 0; k < K; k++) begin
        raw_time_r[k]   <= '0;
        press_time_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          kdsl_pkg::REG_DEBOUNCE:    debounce_r    <= cfg_wdata;
          kdsl_pkg::REG_LONG_PRESS:  long_press_r  <= cfg_wdata;
          kdsl_pkg::REG_ACTIVE_HIGH: active_high_r <= cfg_wdata[K-1:0];
          kdsl_pkg::REG_LONG_ENABLE: long_en_r     <= cfg_wdata[K-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        out_valid_r  <= 1'b1;
        raw_r        <= raw_nxt;
        stable_r     <= stable_nxt;
        long_given_r <= long_given_nxt;
        for (int k = 0; k < K; k++) begin
          raw_time_r[k]   <= raw_time_nxt[k];
          press_time_r[k] <= press_time_nxt[k];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted poll
  always_ff @(posedge clk) begin
    if (in_fire) begin
      evt_r  <= evt_nxt;
      mask_r <= mask_nxt;
    end
  end

endmodule

// ----- rtl/core/kdsl_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsl_chk: port-level checks for the key debouncer
// Watches the poll and result channels and flags handshake or code slips.
// ----------------------------------------------------------------------------
module kdsl_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [kdsl_pkg::OUT_DATA_W-1:0] out_tdata
);

  // no result beat right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // every accepted poll shows a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted poll gave no result");

  // a waiting result blocks the poll side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("poll accepted while result stalled");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // event code stays in range
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != kdsl_pkg::EVT_INVALID)
    else $error("event code out of range");

endmodule

bind key_debounce_short_long_press kdsl_chk u_kdsl_chk (.*);
